// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion helpers
// Same-cycle and next-cycle implications, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg: shared constants and helpers of the line stepper
// Opcodes, default widths and the queue entry layout size
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // entry: {is_start, x0, y0, x1, y1, dx, dy, step_x_neg, step_y_neg}
  function automatic int unsigned entry_width(input int unsigned coord_bits);
    return 1 + 4 * coord_bits + 2 * (coord_bits + 1) + 2;
  endfunction

endpackage

// ===== src/bresenham_line_stepper.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper: all-octant integer line rasteriser
// One item in, one pixel result out, across a short queue
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): opcode_i selects start, which loads
// both endpoints, or next, which asks for the following pixel of the line.
// Output channel (out_valid_o / out_stall_i): one result per item, carrying
// pixel_x_o, pixel_y_o, pixel_valid_o (low for a next with no active line)
// and last_pixel_o (high on the line's end point).
// Path: a result passes through the queue and then the output register, and a
// stall on the output can keep its item waiting in the queue.
// Throughput: one item per cycle while the output is not stalled; the back stepper
// updates the error term and the pixel from two tests of one doubled error.
// The queue holds two items, so the input keeps flowing while a result waits.
// A stall on the output holds the result register steady; the queue then fills
// and in_stall_o rises.
// Reset clears the queue, the output valid flag and the active-line flag; no
// line is in progress afterwards.
// ----------------------------------------------------------------------------
module bresenham_line_stepper import bls_pkg::*; #(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         pixel_valid_o,
  output logic                         last_pixel_o
);

  localparam int unsigned ENTRY_W = entry_width(COORD_BITS);

  logic [ENTRY_W-1:0] front_entry, queue_entry;
  logic               queue_full, queue_empty, queue_pop;

  assign in_stall_o = queue_full;

  bls_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .opcode_i  (opcode_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .entry_o   (front_entry)
  );

  bls_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_entry),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_entry),
    .full_o      (queue_full),
    .empty_o     (queue_empty)
  );

  bls_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (queue_entry),
    .entry_empty_i (queue_empty),
    .entry_pop_o   (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_valid_o (pixel_valid_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// ===== src/bls_front.sv =====
// ----------------------------------------------------------------------------
// bls_front: item intake and line set-up
// Classifies each item and works out deltas and step directions for starts
// ----------------------------------------------------------------------------
module bls_front import bls_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ENTRY_W    = entry_width(COORD_BITS)
) (
  input  logic                         opcode_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic [ENTRY_W-1:0]           entry_o
);

  localparam int unsigned DW = COORD_BITS + 1;

  logic signed [DW-1:0] x0_ext, y0_ext, x1_ext, y1_ext;
  logic [DW-1:0]        dx, dy;
  logic                 step_x_neg, step_y_neg, is_start;

  always_comb begin
    x0_ext = DW'(start_x_i);
    y0_ext = DW'(start_y_i);
    x1_ext = DW'(end_x_i);
    y1_ext = DW'(end_y_i);
    step_x_neg = !(start_x_i < end_x_i);
    step_y_neg = !(start_y_i < end_y_i);
    dx = step_x_neg ? DW'(x0_ext - x1_ext) : DW'(x1_ext - x0_ext);
    dy = step_y_neg ? DW'(y0_ext - y1_ext) : DW'(y1_ext - y0_ext);
    is_start = (opcode_i == OP_START);
  end

  assign entry_o = {is_start, start_x_i, start_y_i, end_x_i, end_y_i,
                    dx, dy, step_x_neg, step_y_neg};

endmodule

// ===== src/bls_queue.sv =====
// ----------------------------------------------------------------------------
// bls_queue: short flop-based queue between front and back
// First in, first out; push and pop may fall in the same cycle
// ----------------------------------------------------------------------------
module bls_queue import bls_pkg::*; #(
  parameter int unsigned WIDTH = entry_width(COORD_BITS_DEF),
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/bls_back.sv =====
// ----------------------------------------------------------------------------
// bls_back: line state and pixel stepping
// Takes one queued item per cycle unless stalled; steps error, registers pixel
// ----------------------------------------------------------------------------
module bls_back import bls_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ENTRY_W    = entry_width(COORD_BITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ENTRY_W-1:0]           entry_i,
  input  logic                         entry_empty_i,
  output logic                         entry_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         pixel_valid_o,
  output logic                         last_pixel_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned DW = C + 1;
  localparam int unsigned EW = C + 2;
  localparam int unsigned XW = C + 3;

  logic                 e_start, e_sxn, e_syn;
  logic signed [C-1:0]  e_x0, e_y0, e_x1, e_y1;
  logic [DW-1:0]        e_dx, e_dy;

  logic signed [C-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [C-1:0]  tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [DW-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic                 sxn_q, sxn_d, syn_q, syn_d;
  logic signed [EW-1:0] err_q, err_d;
  logic                 active_q, active_d;

  logic                 out_valid_q;
  logic signed [C-1:0]  px_q, px_d, py_q, py_d;
  logic                 pvalid_q, pvalid_d, plast_q, plast_d;

  logic signed [XW-1:0] e2;
  logic                 move_x, move_y, last;
  logic                 pop;

  assign {e_start, e_x0, e_y0, e_x1, e_y1, e_dx, e_dy, e_sxn, e_syn} = entry_i;

  // output slot free or draining this cycle
  assign pop         = !entry_empty_i && (!out_valid_q || !out_stall_i);
  assign entry_pop_o = pop;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    sxn_d    = sxn_q;
    syn_d    = syn_q;
    err_d    = err_q;
    active_d = active_q;
    e2       = XW'({err_q, 1'b0});
    move_x   = e2 > -$signed(XW'({2'b00, dy_q}));
    move_y   = e2 < $signed(XW'({2'b00, dx_q}));
    last     = 1'b0;
    px_d     = '0;
    py_d     = '0;
    pvalid_d = 1'b0;
    plast_d  = 1'b0;

    if (e_start) begin
      cur_x_d  = e_x0;
      cur_y_d  = e_y0;
      tgt_x_d  = e_x1;
      tgt_y_d  = e_y1;
      dx_d     = e_dx;
      dy_d     = e_dy;
      sxn_d    = e_sxn;
      syn_d    = e_syn;
      err_d    = EW'({1'b0, e_dx}) - EW'({1'b0, e_dy});
      last     = (e_x0 == e_x1) && (e_y0 == e_y1);
      active_d = !last;
      px_d     = e_x0;
      py_d     = e_y0;
      pvalid_d = 1'b1;
      plast_d  = last;
    end else if (active_q) begin
      // both tests share the same doubled error
      err_d = err_q - (move_x ? EW'({1'b0, dy_q}) : '0)
                    + (move_y ? EW'({1'b0, dx_q}) : '0);
      if (move_x) begin
        cur_x_d = sxn_q ? C'(cur_x_q - 1'b1) : C'(cur_x_q + 1'b1);
      end
      if (move_y) begin
        cur_y_d = syn_q ? C'(cur_y_q - 1'b1) : C'(cur_y_q + 1'b1);
      end
      last     = (cur_x_d == tgt_x_q) && (cur_y_d == tgt_y_q);
      active_d = !last;
      px_d     = cur_x_d;
      py_d     = cur_y_d;
      pvalid_d = 1'b1;
      plast_d  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sxn_q       <= 1'b0;
      syn_q       <= 1'b0;
      err_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        cur_x_q  <= cur_x_d;
        cur_y_q  <= cur_y_d;
        tgt_x_q  <= tgt_x_d;
        tgt_y_q  <= tgt_y_d;
        dx_q     <= dx_d;
        dy_q     <= dy_d;
        sxn_q    <= sxn_d;
        syn_q    <= syn_d;
        err_q    <= err_d;
        active_q <= active_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      px_q     <= px_d;
      py_q     <= py_d;
      pvalid_q <= pvalid_d;
      plast_q  <= plast_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_valid_o = pvalid_q;
  assign last_pixel_o  = plast_q;

endmodule

// ===== src/bls_checker.sv =====
// ----------------------------------------------------------------------------
// bls_checker: port-level checks of the line stepper
// Watches the result channel and the content of invalid results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bls_checker import bls_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [COORD_BITS-1:0] pixel_x_o,
  input logic signed [COORD_BITS-1:0] pixel_y_o,
  input logic                         pixel_valid_o,
  input logic                         last_pixel_o
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // and keeps its content
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
               $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(last_pixel_o))

  // an item with no active line gives an all-zero result
  `ASSERT_IMPLIES(a_idle_zero, clk_i, rst_ni, out_valid_o && !pixel_valid_o,
                  pixel_x_o == '0 && pixel_y_o == '0 && !last_pixel_o)

  // only a real pixel can end a line
  `ASSERT_IMPLIES(a_last_valid, clk_i, rst_ni, out_valid_o && last_pixel_o, pixel_valid_o)

endmodule

bind bresenham_line_stepper bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (.*);
